[rtl/ptp_pkg.sv]
// Shared types, widths and codes of the pulse train player.
package ptp_pkg;

    // Default sizes handed to the top level
    localparam int ENTRY_DEPTH_DEF = 256;
    localparam int TIMER_BITS_DEF  = 24;

    // Fixed field widths
    localparam int CMD_W = 2;
    localparam int DUR_W = 24;
    localparam int REP_W = 16;
    localparam int GAP_W = 24;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_US       = 1'b1;

    // Reset values of the configuration registers
    localparam logic [REP_W-1:0] REPEAT_COUNT_RST = 16'd1;
    localparam logic [GAP_W-1:0] GAP_US_RST       = 24'd0;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    // Playback phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PLAY = 2'd1,
        PH_GAP  = 2'd2
    } phase_t;

    // Request sequencer
    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } ctl_state_t;

endpackage

[rtl/ptp_req_if.sv]
// Request channel of the pulse train player: command and duration.
interface ptp_req_if;
    logic                            valid;
    logic                            ready;
    logic [ptp_pkg::CMD_W-1:0]       command;
    logic signed [ptp_pkg::DUR_W-1:0] duration;

    modport source (output valid, output command, output duration, input ready);
    modport sink   (input valid, input command, input duration, output ready);
endinterface

[rtl/ptp_rsp_if.sv]
// Result channel of the pulse train player: pin level and status flags.
interface ptp_rsp_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic done_res;
    logic load_rejected;

    modport source (output valid, output pin_level, output busy_res, output done_res,
                    output load_rejected, input ready);
    modport sink   (input valid, input pin_level, input busy_res, input done_res,
                    input load_rejected, output ready);
endinterface

[rtl/ptp_sat.sv]
// Saturation of a 24-bit tick count to the timer width.
module ptp_sat #(
    parameter int TIMER_BITS = ptp_pkg::TIMER_BITS_DEF
) (
    input  logic [ptp_pkg::DUR_W-1:0] value,
    output logic [TIMER_BITS-1:0]     ticks
);

    localparam int WIDE_W = (TIMER_BITS > ptp_pkg::DUR_W) ? TIMER_BITS : ptp_pkg::DUR_W;
    localparam logic [WIDE_W-1:0] TIMER_MAX = WIDE_W'({TIMER_BITS{1'b1}});

    logic [WIDE_W-1:0] value_wide;

    // Clamp to the largest count the timer holds
    always_comb
    begin
        value_wide = WIDE_W'(value);
        if (value_wide > TIMER_MAX)
        begin
            ticks = TIMER_BITS'(TIMER_MAX);
        end
        else
        begin
            ticks = TIMER_BITS'(value_wide);
        end
    end

endmodule

[rtl/pulse_train_player.sv]
// Pulse train player top level: entry memory, playback state and request sequencer.
//
// Each request has an accept step and an update step: on accept the entry memory is read at
// the address the request will need (entry 0 for a start or a new pass, the following entry
// while a pass plays), and in the update step the state is updated from the registered read
// data and an append is written. With its single registered memory read port the block takes
// no new request until the update step of the last one is done. Every request gives exactly
// one result, held in an output register; a new request is taken while an earlier result
// still waits, and only the update step stalls until the output register is free.
// Configuration writes take effect at once and are meant for times when playback is idle.
module pulse_train_player #(
    parameter int ENTRY_DEPTH = ptp_pkg::ENTRY_DEPTH_DEF,
    parameter int TIMER_BITS  = ptp_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptp_pkg::CFG_W-1:0]     cfg_wr_data,
    ptp_req_if.sink                       request,
    ptp_rsp_if.source                     result
);

    localparam int IDX_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);
    localparam int DUR_W = ptp_pkg::DUR_W;

    // Entry memory
    logic [DUR_W-1:0] entry_mem [ENTRY_DEPTH];
    logic [DUR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;

    // Configuration
    logic [ptp_pkg::REP_W-1:0] repeat_count_reg;
    logic [ptp_pkg::GAP_W-1:0] gap_us_reg;

    // Playback state
    logic [CNT_W-1:0]          entry_count_reg,   entry_count_next;
    logic [IDX_W-1:0]          play_index_reg,    play_index_next;
    logic [TIMER_BITS-1:0]     remaining_reg,     remaining_next;
    logic [ptp_pkg::REP_W-1:0] passes_left_reg,   passes_left_next;
    ptp_pkg::phase_t           phase_reg,         phase_next;
    logic                      level_reg,         level_next;

    // Sequencer and latched request
    ptp_pkg::ctl_state_t       ctl_state_reg,     ctl_state_next;
    ptp_pkg::cmd_t             cmd_reg;
    logic [DUR_W-1:0]          dur_reg;
    logic                      req_fire;
    logic                      exec_fire;

    // Output register
    logic                      out_valid_reg,     out_valid_next;
    logic                      done_flag;
    logic                      rejected_flag;

    // Entry decode
    logic                      entry_neg;
    logic [DUR_W-1:0]          entry_mag;
    logic [TIMER_BITS-1:0]     entry_ticks;
    logic [TIMER_BITS-1:0]     gap_ticks;
    logic [CNT_W-1:0]          next_index_wide;
    logic                      next_in_list;
    logic [TIMER_BITS-1:0]     remaining_dec;
    logic [ptp_pkg::REP_W-1:0] passes_dec;
    logic                      busy;

    // ---------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg <= ptp_pkg::REPEAT_COUNT_RST;
            gap_us_reg       <= ptp_pkg::GAP_US_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ptp_pkg::REG_REPEAT_COUNT: repeat_count_reg <= cfg_wr_data[ptp_pkg::REP_W-1:0];
                ptp_pkg::REG_GAP_US:       gap_us_reg       <= cfg_wr_data[ptp_pkg::GAP_W-1:0];
                default:                   gap_us_reg       <= gap_us_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        ctl_state_next = ctl_state_reg;
        case (ctl_state_reg)
            ptp_pkg::CTL_IDLE:
            begin
                if (request.valid)
                begin
                    ctl_state_next = ptp_pkg::CTL_EXEC;
                end
            end
            ptp_pkg::CTL_EXEC:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    ctl_state_next = ptp_pkg::CTL_IDLE;
                end
            end
            default: ctl_state_next = ptp_pkg::CTL_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        request.ready = 1'b0;
        exec_fire     = 1'b0;
        case (ctl_state_reg)
            ptp_pkg::CTL_IDLE: request.ready = 1'b1;
            ptp_pkg::CTL_EXEC: exec_fire     = !out_valid_reg || result.ready;
            default:           request.ready = 1'b0;
        endcase
    end

    assign req_fire = request.valid && request.ready;

    // ---------------------------------------------------------------------------------
    // Pick the entry the request will need and read it on accept
    // ---------------------------------------------------------------------------------
    assign next_index_wide = CNT_W'(play_index_reg) + CNT_W'(1);
    assign next_in_list    = next_index_wide < entry_count_reg;

    always_comb
    begin
        if (phase_reg == ptp_pkg::PH_PLAY && next_in_list)
        begin
            rd_addr = play_index_reg + IDX_W'(1);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Memory read and write ports
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
        if (mem_we)
        begin
            entry_mem[wr_addr] <= dur_reg;
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= ptp_pkg::cmd_t'(request.command);
            dur_reg <= request.duration;
        end
    end

    // ---------------------------------------------------------------------------------
    // Decode the fetched entry: sign gives the level, magnitude the length
    // ---------------------------------------------------------------------------------
    assign entry_neg = rd_data_reg[DUR_W-1];
    assign entry_mag = entry_neg ? (~rd_data_reg + DUR_W'(1)) : rd_data_reg;

    ptp_sat #(.TIMER_BITS(TIMER_BITS)) u_entry_sat (
        .value (entry_mag),
        .ticks (entry_ticks)
    );

    ptp_sat #(.TIMER_BITS(TIMER_BITS)) u_gap_sat (
        .value (gap_us_reg),
        .ticks (gap_ticks)
    );

    assign remaining_dec = remaining_reg - TIMER_BITS'(1);
    assign passes_dec    = passes_left_reg - ptp_pkg::REP_W'(1);
    assign busy          = phase_reg != ptp_pkg::PH_IDLE;
    assign wr_addr       = entry_count_reg[IDX_W-1:0];

    // ---------------------------------------------------------------------------------
    // Update step
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        entry_count_next = entry_count_reg;
        play_index_next  = play_index_reg;
        remaining_next   = remaining_reg;
        passes_left_next = passes_left_reg;
        phase_next       = phase_reg;
        level_next       = level_reg;
        done_flag        = 1'b0;
        rejected_flag    = 1'b0;
        mem_we           = 1'b0;

        if (exec_fire)
        begin
            case (cmd_reg)
                ptp_pkg::CMD_CLEAR:
                begin
                    if (!busy)
                    begin
                        entry_count_next = '0;
                    end
                end
                ptp_pkg::CMD_APPEND:
                begin
                    if (busy || entry_count_reg >= CNT_W'(ENTRY_DEPTH))
                    begin
                        rejected_flag = 1'b1;
                    end
                    else if (dur_reg != '0)
                    begin
                        mem_we           = 1'b1;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                end
                ptp_pkg::CMD_START:
                begin
                    if (!busy)
                    begin
                        if (entry_count_reg == '0 || repeat_count_reg == '0)
                        begin
                            level_next = 1'b0;
                            done_flag  = 1'b1;
                        end
                        else
                        begin
                            // Begin the first pass on entry 0
                            passes_left_next = repeat_count_reg;
                            phase_next       = ptp_pkg::PH_PLAY;
                            play_index_next  = '0;
                            level_next       = !entry_neg;
                            remaining_next   = entry_ticks;
                        end
                    end
                end
                ptp_pkg::CMD_TICK:
                begin
                    if (phase_reg == ptp_pkg::PH_PLAY)
                    begin
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            if (next_in_list)
                            begin
                                // Advance to the following entry
                                play_index_next = play_index_reg + IDX_W'(1);
                                level_next      = !entry_neg;
                                remaining_next  = entry_ticks;
                            end
                            else
                            begin
                                level_next       = 1'b0;
                                passes_left_next = passes_dec;
                                if (passes_dec == '0)
                                begin
                                    phase_next      = ptp_pkg::PH_IDLE;
                                    play_index_next = '0;
                                    done_flag       = 1'b1;
                                end
                                else if (gap_us_reg == '0)
                                begin
                                    // No gap: restart on entry 0 at once
                                    play_index_next = '0;
                                    level_next      = !entry_neg;
                                    remaining_next  = entry_ticks;
                                end
                                else
                                begin
                                    phase_next     = ptp_pkg::PH_GAP;
                                    remaining_next = gap_ticks;
                                end
                            end
                        end
                    end
                    else if (phase_reg == ptp_pkg::PH_GAP)
                    begin
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            phase_next      = ptp_pkg::PH_PLAY;
                            play_index_next = '0;
                            level_next      = !entry_neg;
                            remaining_next  = entry_ticks;
                        end
                    end
                end
                default: rejected_flag = 1'b0;
            endcase
        end
    end

    // Hold the result until it is taken
    always_comb
    begin
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_state_reg   <= ptp_pkg::CTL_IDLE;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
            play_index_reg  <= '0;
            remaining_reg   <= '0;
            passes_left_reg <= '0;
            phase_reg       <= ptp_pkg::PH_IDLE;
            level_reg       <= 1'b0;
        end
        else
        begin
            ctl_state_reg   <= ctl_state_next;
            out_valid_reg   <= out_valid_next;
            entry_count_reg <= entry_count_next;
            play_index_reg  <= play_index_next;
            remaining_reg   <= remaining_next;
            passes_left_reg <= passes_left_next;
            phase_reg       <= phase_next;
            level_reg       <= level_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            result.pin_level     <= level_next;
            result.busy_res      <= phase_next != ptp_pkg::PH_IDLE;
            result.done_res      <= done_flag;
            result.load_rejected <= rejected_flag;
        end
    end

    assign result.valid = out_valid_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    a_play_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != ptp_pkg::PH_IDLE |-> remaining_reg != '0)
        else $error("active phase with an empty timer");

    a_index_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ptp_pkg::PH_PLAY |-> CNT_W'(play_index_reg) < entry_count_reg)
        else $error("play index beyond the stored list");

    a_list_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(entry_count_reg) |-> $past(phase_reg) == ptp_pkg::PH_IDLE)
        else $error("entry list changed during playback");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.done_res |-> !result.busy_res && !result.pin_level)
        else $error("done reported while still playing");

endmodule
